FILE: rtl/core/rpi_pkg.sv
package rpi_pkg;

  localparam int RPI_COORD_BITS   = 21;
  localparam int RPI_UV_FRAC_BITS = 16;
  localparam int RPI_UV_BITS      = 24;
  // width of one slice of t's numerator in the hit point multiply
  localparam int RPI_CHUNK_BITS   = 23;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_TOP_LEFT     = 3'd0;
  localparam cfg_idx_t CFG_TOP_RIGHT    = 3'd1;
  localparam cfg_idx_t CFG_BOTTOM_LEFT  = 3'd2;
  localparam cfg_idx_t CFG_DOUBLE_SIDED = 3'd3;

endpackage

FILE: rtl/core/rpi_div_pipe.sv
module rpi_div_pipe #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 4,
  parameter int QUO_W = 4
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  // restoring division, one quotient bit per stage, MSB first
  logic [NUM_W-1:0] rem_r [QUO_W];
  logic [NUM_W-1:0] dvs_r [QUO_W];
  logic [QUO_W-1:0] q_r   [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [NUM_W-1:0] dvs_in;
    logic [NUM_W-1:0] sh;
    logic [QUO_W-1:0] q_in;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign dvs_in = NUM_W'(den);
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign dvs_in = dvs_r[i-1];
      assign q_in   = q_r[i-1];
    end

    assign sh = dvs_in << (QUO_W - 1 - i);
    assign ge = rem_in >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? rem_in - sh : rem_in;
        dvs_r[i] <= dvs_in;
        q_r[i]   <= {q_in[QUO_W-2:0], ge};
      end
    end
  end

  assign quo = q_r[QUO_W-1];

endmodule

FILE: rtl/core/ray_parallelogram_intersect_top.sv
// Segment against parallelogram panel intersector. The user must write the
// panel corners and the double_sided flag through the cfg port while no beat
// is in flight; the block does not enforce it. A segment beat is taken every
// cycle unless in_stall is high. Results pass nine stages of cross products,
// dot products, sign fixup and numerator setup, then a 24-stage restoring
// divider (one quotient bit per stage, five dividers in lockstep for u, v
// and the hit point x, y, z), then the output register. A stalled output
// stops the pipeline only when the last divider stage holds a beat; bubbles
// ahead are squeezed out, so input beats keep flowing while a result waits.
module ray_parallelogram_intersect_top #(
  parameter int COORD_BITS   = rpi_pkg::RPI_COORD_BITS,
  parameter int UV_FRAC_BITS = rpi_pkg::RPI_UV_FRAC_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  rpi_pkg::cfg_idx_t                      cfg_index,
  input  logic [3*COORD_BITS-1:0]                cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [COORD_BITS-1:0]           in_start_x,
  input  logic signed [COORD_BITS-1:0]           in_start_y,
  input  logic signed [COORD_BITS-1:0]           in_start_z,
  input  logic signed [COORD_BITS-1:0]           in_end_x,
  input  logic signed [COORD_BITS-1:0]           in_end_y,
  input  logic signed [COORD_BITS-1:0]           in_end_z,
  input  logic                                   in_allow_outside,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic                                   out_hit,
  output logic signed [rpi_pkg::RPI_UV_BITS-1:0] out_coord_u,
  output logic signed [rpi_pkg::RPI_UV_BITS-1:0] out_coord_v,
  output logic signed [COORD_BITS-1:0]           out_hit_world_x,
  output logic signed [COORD_BITS-1:0]           out_hit_world_y,
  output logic signed [COORD_BITS-1:0]           out_hit_world_z
);
  import rpi_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int DW   = CB + 1;
  localparam int CW   = 2 * DW + 1;
  localparam int PW   = CW + DW;
  localparam int SW   = PW + 2;
  localparam int UVF  = UV_FRAC_BITS;
  localparam int UVB  = RPI_UV_BITS;
  localparam int QB   = UVB;
  localparam int CH   = RPI_CHUNK_BITS;
  localparam int NCH  = (SW + CH - 1) / CH;
  localparam int PPW  = CH + 1 + DW;
  localparam int MW   = NCH * CH + DW + 1;
  localparam int XT0  = (DW > UVF + 1) ? DW : UVF + 1;
  localparam int XT   = (XT0 > QB) ? XT0 : QB;
  localparam int NW   = SW + XT + 3;
  localparam int DDW  = SW + 1;
  localparam int NST  = 9;

  localparam int I1 [3] = '{1, 2, 0};
  localparam int I2 [3] = '{2, 0, 1};

  // config registers
  logic [3*CB-1:0] tl_r, tr_r, bl_r;
  logic            ds_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tl_r <= '0;
      tr_r <= '0;
      bl_r <= '0;
      ds_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TOP_LEFT:     tl_r <= cfg_data;
        CFG_TOP_RIGHT:    tr_r <= cfg_data;
        CFG_BOTTOM_LEFT:  bl_r <= cfg_data;
        CFG_DOUBLE_SIDED: ds_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic            adv;
  logic [NST-1:0]  v_r;
  logic [QB-1:0]   dl_v_r;
  logic            out_valid_r;

  assign adv      = !(out_valid_r && out_stall && dl_v_r[QB-1]);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r    <= '0;
      dl_v_r <= '0;
    end else if (adv) begin
      v_r    <= {v_r[NST-2:0], in_valid};
      dl_v_r <= {dl_v_r[QB-2:0], v_r[NST-1]};
    end
  end

  // stage 1: edge, direction and offset vectors
  logic signed [CB-1:0] tl [3], tr [3], bl [3], st [3], ed [3];
  logic signed [DW-1:0] s1_rv_nxt [3], s1_wv_nxt [3], s1_dv_nxt [3], s1_ov_nxt [3];
  logic signed [DW-1:0] s1_rv_r [3], s1_wv_r [3], s1_dv_r [3], s1_ov_r [3];
  logic signed [CB-1:0] s1_s_r [3];
  logic                 s1_allow_r;

  assign st = '{in_start_x, in_start_y, in_start_z};
  assign ed = '{in_end_x, in_end_y, in_end_z};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tl[k] = tl_r[k*CB +: CB];
      tr[k] = tr_r[k*CB +: CB];
      bl[k] = bl_r[k*CB +: CB];
      s1_rv_nxt[k] = DW'(tr[k]) - DW'(tl[k]);
      s1_wv_nxt[k] = DW'(bl[k]) - DW'(tl[k]);
      s1_dv_nxt[k] = DW'(ed[k]) - DW'(st[k]);
      s1_ov_nxt[k] = DW'(st[k]) - DW'(tl[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rv_r    <= s1_rv_nxt;
      s1_wv_r    <= s1_wv_nxt;
      s1_dv_r    <= s1_dv_nxt;
      s1_ov_r    <= s1_ov_nxt;
      s1_s_r     <= st;
      s1_allow_r <= in_allow_outside;
    end
  end

  // stage 2: cross product terms
  logic signed [2*DW-1:0] s2_nh_r [3], s2_nl_r [3], s2_wh_r [3], s2_wl_r [3];
  logic signed [2*DW-1:0] s2_oh_r [3], s2_ol_r [3];
  logic signed [DW-1:0]   s2_rv_r [3], s2_dv_r [3], s2_ov_r [3];
  logic signed [CB-1:0]   s2_s_r [3];
  logic                   s2_allow_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s2_nh_r[k] <= s1_rv_r[I1[k]] * s1_wv_r[I2[k]];
        s2_nl_r[k] <= s1_rv_r[I2[k]] * s1_wv_r[I1[k]];
        s2_wh_r[k] <= s1_wv_r[I1[k]] * s1_dv_r[I2[k]];
        s2_wl_r[k] <= s1_wv_r[I2[k]] * s1_dv_r[I1[k]];
        s2_oh_r[k] <= s1_ov_r[I1[k]] * s1_dv_r[I2[k]];
        s2_ol_r[k] <= s1_ov_r[I2[k]] * s1_dv_r[I1[k]];
      end
      s2_rv_r    <= s1_rv_r;
      s2_dv_r    <= s1_dv_r;
      s2_ov_r    <= s1_ov_r;
      s2_s_r     <= s1_s_r;
      s2_allow_r <= s1_allow_r;
    end
  end

  // stage 3: cross products N, W x D, O x D
  logic signed [CW-1:0] s3_n_r [3], s3_wxd_r [3], s3_oxd_r [3];
  logic signed [DW-1:0] s3_rv_r [3], s3_dv_r [3], s3_ov_r [3];
  logic signed [CB-1:0] s3_s_r [3];
  logic                 s3_allow_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s3_n_r[k]   <= CW'(s2_nh_r[k]) - CW'(s2_nl_r[k]);
        s3_wxd_r[k] <= CW'(s2_wh_r[k]) - CW'(s2_wl_r[k]);
        s3_oxd_r[k] <= CW'(s2_oh_r[k]) - CW'(s2_ol_r[k]);
      end
      s3_rv_r    <= s2_rv_r;
      s3_dv_r    <= s2_dv_r;
      s3_ov_r    <= s2_ov_r;
      s3_s_r     <= s2_s_r;
      s3_allow_r <= s2_allow_r;
    end
  end

  // stage 4: dot product terms
  logic signed [PW-1:0] s4_dp_r [3], s4_op_r [3], s4_up_r [3], s4_vp_r [3];
  logic signed [DW-1:0] s4_dv_r [3];
  logic signed [CB-1:0] s4_s_r [3];
  logic                 s4_allow_r, s4_nzero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s4_dp_r[k] <= s3_n_r[k] * s3_dv_r[k];
        s4_op_r[k] <= s3_n_r[k] * s3_ov_r[k];
        s4_up_r[k] <= s3_wxd_r[k] * s3_ov_r[k];
        s4_vp_r[k] <= s3_oxd_r[k] * s3_rv_r[k];
      end
      s4_nzero_r <= (s3_n_r[0] == '0) && (s3_n_r[1] == '0) && (s3_n_r[2] == '0);
      s4_dv_r    <= s3_dv_r;
      s4_s_r     <= s3_s_r;
      s4_allow_r <= s3_allow_r;
    end
  end

  // stage 5: den, N.O, u and v numerators
  logic signed [SW-1:0] s5_den_r, s5_no_r, s5_nu_r, s5_nv_r;
  logic signed [DW-1:0] s5_dv_r [3];
  logic signed [CB-1:0] s5_s_r [3];
  logic                 s5_allow_r, s5_nzero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_den_r   <= SW'(s4_dp_r[0]) + SW'(s4_dp_r[1]) + SW'(s4_dp_r[2]);
      s5_no_r    <= SW'(s4_op_r[0]) + SW'(s4_op_r[1]) + SW'(s4_op_r[2]);
      s5_nu_r    <= SW'(s4_up_r[0]) + SW'(s4_up_r[1]) + SW'(s4_up_r[2]);
      s5_nv_r    <= SW'(s4_vp_r[0]) + SW'(s4_vp_r[1]) + SW'(s4_vp_r[2]);
      s5_nzero_r <= s4_nzero_r;
      s5_dv_r    <= s4_dv_r;
      s5_s_r     <= s4_s_r;
      s5_allow_r <= s4_allow_r;
    end
  end

  // stage 6: make den positive, range tests
  logic                 neg;
  logic signed [SW-1:0] s6_den_nxt, s6_nt_nxt, s6_nu_nxt, s6_nv_nxt;
  logic                 s6_miss_nxt;
  logic signed [SW-1:0] s6_den_r, s6_nt_r, s6_nu_r;
  logic signed [SW-1:0] s6_nv_r;
  logic signed [DW-1:0] s6_dv_r [3];
  logic signed [CB-1:0] s6_s_r [3];
  logic                 s6_miss_r;

  always_comb begin
    neg         = s5_den_r[SW-1];
    s6_den_nxt  = neg ? -s5_den_r : s5_den_r;
    s6_nt_nxt   = neg ? s5_no_r : -s5_no_r;
    s6_nu_nxt   = neg ? -s5_nu_r : s5_nu_r;
    s6_nv_nxt   = neg ? -s5_nv_r : s5_nv_r;
    s6_miss_nxt = s5_nzero_r || (s5_den_r == '0) || (!ds_r && !neg) ||
                  s6_nt_nxt[SW-1] || (s6_nt_nxt > s6_den_nxt) ||
                  (!s5_allow_r && (s6_nu_nxt[SW-1] || (s6_nu_nxt >= s6_den_nxt) ||
                                   s6_nv_nxt[SW-1] || (s6_nv_nxt >= s6_den_nxt)));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_den_r  <= s6_den_nxt;
      s6_nt_r   <= s6_nt_nxt;
      s6_nu_r   <= s6_nu_nxt;
      s6_nv_r   <= s6_nv_nxt;
      s6_miss_r <= s6_miss_nxt;
      s6_dv_r   <= s5_dv_r;
      s6_s_r    <= s5_s_r;
    end
  end

  // stage 7: t * D partial products, offset u and v dividends
  logic [NCH*CH-1:0]     ntp;
  logic signed [PPW-1:0] s7_pp_r [3][NCH];
  logic signed [NW-1:0]  s7_un_r, s7_vn_r;
  logic signed [SW-1:0]  s7_den_r;
  logic signed [CB-1:0]  s7_s_r [3];
  logic                  s7_miss_r;

  assign ntp = (NCH*CH)'(s6_nt_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < NCH; j++) begin
          s7_pp_r[k][j] <= $signed({1'b0, ntp[j*CH +: CH]}) * s6_dv_r[k];
        end
      end
      s7_un_r   <= (NW'(s6_nu_r) <<< (UVF + 1)) + NW'(s6_den_r) + (NW'(s6_den_r) <<< UVB);
      s7_vn_r   <= (NW'(s6_nv_r) <<< (UVF + 1)) + NW'(s6_den_r) + (NW'(s6_den_r) <<< UVB);
      s7_den_r  <= s6_den_r;
      s7_miss_r <= s6_miss_r;
      s7_s_r    <= s6_s_r;
    end
  end

  // stage 8: t * D sums, u and v output range check
  logic signed [MW-1:0] m_acc [3];
  logic signed [NW-1:0] lim;
  logic signed [MW-1:0] s8_m_r [3];
  logic signed [NW-1:0] s8_un_r, s8_vn_r;
  logic signed [SW-1:0] s8_den_r;
  logic signed [CB-1:0] s8_s_r [3];
  logic                 s8_miss_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      m_acc[k] = '0;
      for (int j = 0; j < NCH; j++) begin
        m_acc[k] = m_acc[k] + (MW'(s7_pp_r[k][j]) <<< (j * CH));
      end
    end
    lim = NW'(s7_den_r) <<< (UVB + 1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_m_r    <= m_acc;
      s8_un_r   <= s7_un_r;
      s8_vn_r   <= s7_vn_r;
      s8_den_r  <= s7_den_r;
      s8_s_r    <= s7_s_r;
      s8_miss_r <= s7_miss_r || s7_un_r[NW-1] || (s7_un_r >= lim) ||
                   s7_vn_r[NW-1] || (s7_vn_r >= lim);
    end
  end

  // stage 9: hit point dividends and divisor
  logic signed [NW-1:0] s9_xn_r [3];
  logic signed [NW-1:0] s9_un_r, s9_vn_r;
  logic [DDW-1:0]       s9_d_r;
  logic signed [CB-1:0] s9_s_r [3];
  logic                 s9_miss_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s9_xn_r[k] <= (NW'(s8_m_r[k]) <<< 1) + NW'(s8_den_r) + (NW'(s8_den_r) <<< UVB);
      end
      s9_un_r   <= s8_un_r;
      s9_vn_r   <= s8_vn_r;
      s9_d_r    <= DDW'(s8_den_r) << 1;
      s9_s_r    <= s8_s_r;
      s9_miss_r <= s8_miss_r;
    end
  end

  // dividers and side data alignment
  logic [QB-1:0]        qu, qv;
  logic [QB-1:0]        qx [3];
  logic                 dl_miss_r [QB];
  logic signed [CB-1:0] dl_s_r [QB][3];

  rpi_div_pipe #(.NUM_W(NW), .DEN_W(DDW), .QUO_W(QB)) u_div_u (
    .clk (clk), .en (adv), .num (s9_un_r), .den (s9_d_r), .quo (qu)
  );

  rpi_div_pipe #(.NUM_W(NW), .DEN_W(DDW), .QUO_W(QB)) u_div_v (
    .clk (clk), .en (adv), .num (s9_vn_r), .den (s9_d_r), .quo (qv)
  );

  for (genvar k = 0; k < 3; k++) begin : g_pt
    rpi_div_pipe #(.NUM_W(NW), .DEN_W(DDW), .QUO_W(QB)) u_div_p (
      .clk (clk), .en (adv), .num (s9_xn_r[k]), .den (s9_d_r), .quo (qx[k])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_miss_r[0] <= s9_miss_r;
      dl_s_r[0]    <= s9_s_r;
      for (int i = 1; i < QB; i++) begin
        dl_miss_r[i] <= dl_miss_r[i-1];
        dl_s_r[i]    <= dl_s_r[i-1];
      end
    end
  end

  // output register
  logic                  hit_nxt;
  logic                  out_hit_r;
  logic signed [UVB-1:0] out_u_r, out_v_r;
  logic signed [CB-1:0]  out_p_r [3];

  assign hit_nxt = !dl_miss_r[QB-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && dl_v_r[QB-1]) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && dl_v_r[QB-1]) begin
      out_hit_r <= hit_nxt;
      out_u_r   <= hit_nxt ? {~qu[QB-1], qu[QB-2:0]} : '0;
      out_v_r   <= hit_nxt ? {~qv[QB-1], qv[QB-2:0]} : '0;
      for (int k = 0; k < 3; k++) begin
        out_p_r[k] <= hit_nxt ? dl_s_r[QB-1][k] + $signed(qx[k][CB-1:0]) : '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_coord_u     = out_u_r;
  assign out_coord_v     = out_v_r;
  assign out_hit_world_x = out_p_r[0];
  assign out_hit_world_y = out_p_r[1];
  assign out_hit_world_z = out_p_r[2];

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_coord_u == '0 && out_coord_v == '0 &&
      out_hit_world_x == '0 && out_hit_world_y == '0 && out_hit_world_z == '0)
    else $error("miss result with nonzero fields");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall && dl_v_r[QB-1])
    else $error("input stalled without a blocked result");

  a_stage_adv: assert property (@(posedge clk) disable iff (!rst_n)
    adv && v_r[0] |=> v_r[1])
    else $error("beat lost between first stages");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    adv && dl_v_r[QB-1] |=> out_valid)
    else $error("finished beat not presented");

endmodule

FILE: verif/ray_parallelogram_intersect_checker.sv
`timescale 1ns / 1ps

module ray_parallelogram_intersect_checker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  rpi_pkg::cfg_idx_t       cfg_index,
  input  logic [62:0]             cfg_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [20:0]      in_start_x,
  input  logic signed [20:0]      in_start_y,
  input  logic signed [20:0]      in_start_z,
  input  logic signed [20:0]      in_end_x,
  input  logic signed [20:0]      in_end_y,
  input  logic signed [20:0]      in_end_z,
  input  logic                    in_allow_outside,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    out_hit,
  input  logic signed [23:0]      out_coord_u,
  input  logic signed [23:0]      out_coord_v,
  input  logic signed [20:0]      out_hit_world_x,
  input  logic signed [20:0]      out_hit_world_y,
  input  logic signed [20:0]      out_hit_world_z,
  output int                      mismatches,
  output int                      outstanding
);
  import rpi_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic               hit;
    logic signed [23:0] u;
    logic signed [23:0] v;
    logic signed [20:0] px;
    logic signed [20:0] py;
    logic signed [20:0] pz;
  } hit_rec_t;

  logic [62:0] corner_tl, corner_tr, corner_bl;
  logic        double_sided;
  hit_rec_t    expected_hits[$];

  assign outstanding = expected_hits.size();

  function automatic void unpack_corner(input logic [62:0] r, output longint p[3]);
    p[0] = longint'(signed'(r[20:0]));
    p[1] = longint'(signed'(r[41:21]));
    p[2] = longint'(signed'(r[62:42]));
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3], output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic wide_t dot3(input longint a[3], input longint b[3]);
    wide_t s;
    s = 0;
    for (int k = 0; k < 3; k++) s += wide_t'(a[k]) * wide_t'(b[k]);
    return s;
  endfunction

  // nearest, ties toward +inf, d > 0
  function automatic wide_t round_div(input wide_t n, input wide_t d);
    wide_t nn, dd, q;
    nn = 2 * n + d;
    dd = 2 * d;
    q = nn / dd;
    if (nn < 0 && q * dd != nn) q = q - 1;
    return q;
  endfunction

  function automatic hit_rec_t intersect_segment(input longint s[3], input longint e[3],
                                                 input logic allow);
    hit_rec_t r;
    longint tl[3], tr[3], bl[3], rv[3], wv[3], dv[3], ov[3], nv[3], wxd[3], oxd[3];
    wide_t den, nt, nu, nvv, uq, vq, step;
    r = '0;
    unpack_corner(corner_tl, tl);
    unpack_corner(corner_tr, tr);
    unpack_corner(corner_bl, bl);
    for (int k = 0; k < 3; k++) begin
      rv[k] = tr[k] - tl[k];
      wv[k] = bl[k] - tl[k];
      dv[k] = e[k] - s[k];
      ov[k] = s[k] - tl[k];
    end
    cross3(rv, wv, nv);
    if (nv[0] == 0 && nv[1] == 0 && nv[2] == 0) return r;
    den = dot3(nv, dv);
    if (den == 0) return r;
    if (!double_sided && den > 0) return r;
    cross3(wv, dv, wxd);
    cross3(ov, dv, oxd);
    nt = -dot3(nv, ov);
    nu = dot3(ov, wxd);
    nvv = dot3(rv, oxd);
    if (den < 0) begin
      den = -den;
      nt = -nt;
      nu = -nu;
      nvv = -nvv;
    end
    if (nt < 0 || nt > den) return r;
    if (!allow && (nu < 0 || nu >= den || nvv < 0 || nvv >= den)) return r;
    uq = round_div(nu * 65536, den);
    vq = round_div(nvv * 65536, den);
    if (uq < -8388608 || uq > 8388607 || vq < -8388608 || vq > 8388607) return r;
    r.hit = 1'b1;
    r.u = uq[23:0];
    r.v = vq[23:0];
    step = round_div(nt * wide_t'(dv[0]), den) + wide_t'(s[0]);
    r.px = step[20:0];
    step = round_div(nt * wide_t'(dv[1]), den) + wide_t'(s[1]);
    r.py = step[20:0];
    step = round_div(nt * wide_t'(dv[2]), den) + wide_t'(s[2]);
    r.pz = step[20:0];
    return r;
  endfunction

  always @(posedge clk) begin
    longint s[3], e[3];
    hit_rec_t want, got;
    if (!rst_n) begin
      corner_tl <= '0;
      corner_tr <= '0;
      corner_bl <= '0;
      double_sided <= 1'b0;
      mismatches <= 0;
      expected_hits.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TOP_LEFT:     corner_tl <= cfg_data;
          CFG_TOP_RIGHT:    corner_tr <= cfg_data;
          CFG_BOTTOM_LEFT:  corner_bl <= cfg_data;
          CFG_DOUBLE_SIDED: double_sided <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        s[0] = longint'(in_start_x); s[1] = longint'(in_start_y);
        s[2] = longint'(in_start_z);
        e[0] = longint'(in_end_x);   e[1] = longint'(in_end_y);
        e[2] = longint'(in_end_z);
        expected_hits.push_back(intersect_segment(s, e, in_allow_outside));
      end
      if (out_valid && !out_stall) begin
        got = {out_hit, out_coord_u, out_coord_v, out_hit_world_x, out_hit_world_y,
               out_hit_world_z};
        if (expected_hits.size() == 0) begin
          if (mismatches < 10) $display("unexpected result beat: %p", got);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_hits.pop_front();
          if (want !== got) begin
            if (mismatches < 10)
              $display({"mismatch: expected hit=%0d u=%0d v=%0d p=(%0d,%0d,%0d)",
                        " got hit=%0d u=%0d v=%0d p=(%0d,%0d,%0d)"},
                       want.hit, want.u, want.v, want.px, want.py, want.pz,
                       got.hit, got.u, got.v, got.px, got.py, got.pz);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import rpi_pkg::*;

  localparam longint CMIN = -1048576;
  localparam longint CMAX = 1048575;
  localparam int     WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_TOP_LEFT;
  logic [62:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [20:0] in_start_x = '0, in_start_y = '0, in_start_z = '0;
  logic signed [20:0] in_end_x = '0, in_end_y = '0, in_end_z = '0;
  logic in_allow_outside = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic signed [23:0] out_coord_u, out_coord_v;
  logic signed [20:0] out_hit_world_x, out_hit_world_y, out_hit_world_z;
  int mismatches, outstanding;

  longint panel_tl[3], panel_tr[3], panel_bl[3];
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int stall_count = 0;

  always #4 clk = ~clk;

  ray_parallelogram_intersect_top dut (.*);

  ray_parallelogram_intersect_checker chk (.*);

  always @(posedge clk) begin
    stall_count <= stall_count + 1;
    if (stall_count % 64 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      2: out_stall <= ($urandom_range(0, 9) < 8);
      default: out_stall <= stall_count[3];
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic longint sat_coord(input longint v);
    if (v < CMIN) return CMIN;
    if (v > CMAX) return CMAX;
    return v;
  endfunction

  function automatic logic [62:0] pack_corner(input longint p[3]);
    return {p[2][20:0], p[1][20:0], p[0][20:0]};
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input logic [62:0] data);
    logic done;
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do begin
      @(negedge clk);
      done = cfg_ready;
      @(posedge clk);
    end while (!done);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_panel(input longint tl[3], input longint tr[3], input longint bl[3],
                            input logic ds);
    panel_tl = tl;
    panel_tr = tr;
    panel_bl = bl;
    write_reg(CFG_TOP_LEFT, pack_corner(tl));
    write_reg(CFG_TOP_RIGHT, pack_corner(tr));
    write_reg(CFG_BOTTOM_LEFT, pack_corner(bl));
    write_reg(CFG_DOUBLE_SIDED,
              63'({$urandom, $urandom}) & 63'h7FFF_FFFF_FFFF_FFFE | 63'(ds));
    write_reg(cfg_idx_t'($urandom_range(4, 7)), 63'({$urandom, $urandom}));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send_segment(input longint s[3], input longint e[3], input logic allow);
    logic done;
    in_start_x <= 21'(s[0]); in_start_y <= 21'(s[1]); in_start_z <= 21'(s[2]);
    in_end_x <= 21'(e[0]);   in_end_y <= 21'(e[1]);   in_end_z <= 21'(e[2]);
    in_allow_outside <= allow;
    in_valid <= 1'b1;
    do begin
      @(negedge clk);
      done = !in_stall;
      @(posedge clk);
    end while (!done);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic send_xyz(input longint sx, sy, sz, ex, ey, ez, input logic allow);
    longint s[3], e[3];
    s = '{sx, sy, sz};
    e = '{ex, ey, ez};
    send_segment(s, e, allow);
  endtask

  // xy-plane panel, 1024 wide; front face is looking down -z
  task automatic directed_segments;
    send_xyz(512, 512, 256, 512, 512, -256, 1'b0);
    send_xyz(512, 512, -256, 512, 512, 256, 1'b0);
    send_xyz(512, 512, 256, 512, 512, 256, 1'b0);
    send_xyz(100, 300, 0, 900, 700, 0, 1'b1);
    send_xyz(512, 512, 512, 512, 512, 256, 1'b0);
    send_xyz(512, 512, 0, 600, 600, -256, 1'b0);
    send_xyz(512, 512, 256, 700, 300, 0, 1'b0);
    send_xyz(5000, 512, 256, 5000, 512, -256, 1'b0);
    send_xyz(5000, 512, 256, 5000, 512, -256, 1'b1);
    send_xyz(1024, 512, 256, 1024, 512, -256, 1'b0);
    send_xyz(0, 0, 256, 0, 0, -256, 1'b0);
    send_xyz(512, -1, 256, 512, -1, -256, 1'b0);
    send_xyz(CMAX, 0, 1, CMAX, 0, -1, 1'b1);
    send_xyz(CMIN, CMIN, 1, CMIN, CMIN, -1, 1'b1);
    send_xyz(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 1'b1);
    send_xyz(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 1'b1);
    send_xyz(CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, 1'b0);
    send_xyz(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 1'b1);
  endtask

  task automatic random_segments(input int count);
    longint s[3], e[3], off[3], tgt[3], rv, wv;
    int a, b, f1, f2;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) begin
        for (int k = 0; k < 3; k++) begin
          s[k] = longint'(signed'(21'($urandom)));
          e[k] = longint'(signed'(21'($urandom)));
        end
      end else begin
        a = $urandom_range(0, 383) - 64;
        b = $urandom_range(0, 383) - 64;
        f1 = $urandom_range(1, 4);
        f2 = $urandom_range(0, 4);
        for (int k = 0; k < 3; k++) begin
          rv = panel_tr[k] - panel_tl[k];
          wv = panel_bl[k] - panel_tl[k];
          tgt[k] = panel_tl[k] + (a * rv + b * wv) / 256;
          off[k] = longint'($urandom_range(0, 8192)) - 4096;
          s[k] = sat_coord(tgt[k] + off[k] * f1);
          e[k] = sat_coord(tgt[k] - off[k] * f2);
        end
      end
      send_segment(s, e, ($urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    longint tl[3], tr[3], bl[3];
    logic [62:0] r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset panel is degenerate
    panel_tl = '{0, 0, 0}; panel_tr = '{0, 0, 0}; panel_bl = '{0, 0, 0};
    random_segments(30);
    drain();

    tl = '{0, 0, 0}; tr = '{1024, 0, 0}; bl = '{0, 1024, 0};
    load_panel(tl, tr, bl, 1'b0);
    directed_segments();
    random_segments(120);
    drain();
    load_panel(tl, tr, bl, 1'b1);
    directed_segments();
    random_segments(120);
    drain();

    tl = '{CMIN, CMIN, 0}; tr = '{CMAX, CMIN, 0}; bl = '{CMIN, CMAX, 0};
    load_panel(tl, tr, bl, 1'b1);
    random_segments(100);
    drain();

    tl = '{CMAX, CMAX, CMAX}; tr = '{CMIN, CMAX, CMIN}; bl = '{CMAX, CMIN, CMIN};
    load_panel(tl, tr, bl, 1'b0);
    random_segments(100);
    drain();

    // collinear corners
    tl = '{100, 200, 300}; tr = '{600, 700, 800}; bl = '{1100, 1200, 1300};
    load_panel(tl, tr, bl, 1'b1);
    random_segments(40);
    drain();

    r = 63'({$urandom, $urandom});
    for (int k = 0; k < 3; k++) tl[k] = longint'(signed'(r[21*k +: 21]));
    r = 63'({$urandom, $urandom});
    for (int k = 0; k < 3; k++) tr[k] = longint'(signed'(r[21*k +: 21]));
    r = 63'({$urandom, $urandom});
    for (int k = 0; k < 3; k++) bl[k] = longint'(signed'(r[21*k +: 21]));
    load_panel(tl, tr, bl, 1'($urandom));
    random_segments(100);
    drain();

    for (int p = 0; p < 6; p++) begin
      for (int k = 0; k < 3; k++) begin
        tl[k] = longint'($urandom_range(0, 100000)) - 50000;
        tr[k] = tl[k] + longint'($urandom_range(0, 20000)) - 10000;
        bl[k] = tl[k] + longint'($urandom_range(0, 20000)) - 10000;
      end
      load_panel(tl, tr, bl, p[0]);
      random_segments(120);
      drain();
    end

    in_valid <= 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
